>>> sv/alm_pkg.sv
// alm_pkg: types, constants and command/status structs for the audio level meter
// used by every module of the block but alm_ram; depends on nothing
package alm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 16;
    localparam int SQ_W       = 31;
    localparam int MAX_FRAME  = 256;
    localparam int FCNT_W     = $clog2(MAX_FRAME + 1);
    localparam int SUM_W      = SQ_W + $clog2(MAX_FRAME);
    localparam int LENGTH_BITS = 24;
    localparam int SEG_W      = 24;
    localparam int LEVEL_W    = 8;
    localparam int THR_W      = 8;
    localparam int HANG_W     = 16;
    localparam int SIL_W      = HANG_W + 1;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam int Q_W        = 64;
    localparam int Q_FRAC     = 60;
    localparam logic [Q_W-1:0] Q_ONE = 64'h1000_0000_0000_0000;
    localparam logic [Q_W-1:0] Q_TWO = 64'h2000_0000_0000_0000;
    localparam logic [Q_W-1:0] Q_TEN = 64'hA000_0000_0000_0000;
    localparam int POW_STEPS  = 7;
    localparam int PCNT_W     = 3;

    localparam int TAB_DEPTH  = 255;
    localparam int TAB_AW     = 8;
    localparam int TAB_W      = 18;
    localparam int T_SHIFT    = 30;
    localparam int T_NUM_W    = Q_W - T_SHIFT + 1;
    localparam int T_HALF     = 50000;
    localparam int T_DIV      = 100000;

    // divide by 100000 as shift by 5, then multiply by ceil(2^41 / 3125)
    localparam int T_PRE_SHIFT   = 5;
    localparam int T_M_W         = T_NUM_W - T_PRE_SHIFT;
    localparam int T_RECIP_SHIFT = 41;
    localparam logic [T_M_W-1:0] T_RECIP = 30'd703687442;

    localparam int DIV_N      = SUM_W;
    localparam int DIV_DW     = FCNT_W;
    localparam int DIV_CW     = $clog2(DIV_N);
    localparam int BIT_W      = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPEECH_THRESHOLD = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HANGOVER_SAMPLES = 1'd1;

    localparam logic [THR_W-1:0]  THR_RESET  = 8'd15;
    localparam logic [HANG_W-1:0] HANG_RESET = 16'd16000;

    typedef enum logic [1:0] {
        MUL_SQ,
        MUL_AC,
        MUL_TX
    } mul_sel_t;

    typedef enum logic [4:0] {
        ST_BIS_INIT,
        ST_BIS_CHECK,
        ST_SQ_START,
        ST_SQ_WAIT,
        ST_AC_START,
        ST_AC_WAIT,
        ST_BIS_UPD,
        ST_TAB_INIT,
        ST_TX_START,
        ST_TX_WAIT,
        ST_TD_START,
        ST_TD_WAIT,
        ST_IDLE,
        ST_MEAN_WAIT,
        ST_SR_ADDR,
        ST_SR_CMP,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic     bis_init;
        logic     bis_load;
        logic     bis_upd;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     sq_load;
        logic     ac_load;
        logic     x_load;
        logic     tab_init;
        logic     tab_div_start;
        logic     tab_write;
        logic     take;
        logic     srch_init;
        logic     srch_cmp;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic bis_done;
        logic mul_done;
        logic div_done;
        logic tab_last;
        logic closing;
        logic bit_zero;
    } st_t;

endpackage

>>> sv/alm_ram.sv
// alm_ram: generic single-port ram with registered read
// no dependencies
module alm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/alm_qmul.sv
// alm_qmul: q4.60 truncating multiply with saturation, four 32x32 partial products
// depends on alm_pkg
module alm_qmul (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [alm_pkg::Q_W-1:0] a,
    input  logic [alm_pkg::Q_W-1:0] b,
    output logic                  done,
    output logic [alm_pkg::Q_W-1:0] y
);

    logic [alm_pkg::Q_W-1:0]   a_reg, b_reg;
    logic [alm_pkg::Q_W-1:0]   prod_reg;
    logic [1:0]                sel_reg;
    logic [2*alm_pkg::Q_W-1:0] acc_reg;
    logic [2:0]                cnt_reg;
    logic                      busy_reg, done_reg;
    logic [31:0]               pa, pb;
    logic [2*alm_pkg::Q_W-1:0] shifted;

    always_comb begin
        case (cnt_reg[1:0])
            2'd0: begin pa = a_reg[31:0];  pb = b_reg[31:0];  end
            2'd1: begin pa = a_reg[31:0];  pb = b_reg[63:32]; end
            2'd2: begin pa = a_reg[63:32]; pb = b_reg[31:0];  end
            default: begin pa = a_reg[63:32]; pb = b_reg[63:32]; end
        endcase
        case (sel_reg)
            2'd0: shifted = {64'd0, prod_reg};
            2'd3: shifted = {prod_reg, 64'd0};
            default: shifted = {32'd0, prod_reg, 32'd0};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                acc_reg  <= '0;
                a_reg    <= a;
                b_reg    <= b;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg != 3'd4) begin
                    prod_reg <= {32'd0, pa} * {32'd0, pb};
                    sel_reg  <= cnt_reg[1:0];
                end
                if (cnt_reg != 3'd0) begin
                    acc_reg <= acc_reg + shifted;
                end
                if (cnt_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign y = (acc_reg[127:124] != 4'd0) ? '1 : acc_reg[123:60];

endmodule

>>> sv/alm_div.sv
// alm_div: restoring divider, one quotient bit per cycle
// depends on alm_pkg
module alm_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [alm_pkg::DIV_N-1:0]  dividend,
    input  logic [alm_pkg::DIV_DW-1:0] divisor,
    output logic                       done,
    output logic [alm_pkg::DIV_N-1:0]  quotient
);

    logic [alm_pkg::DIV_N-1:0]  q_reg;
    logic [alm_pkg::DIV_DW-1:0] rem_reg, dvs_reg;
    logic [alm_pkg::DIV_CW-1:0] cnt_reg;
    logic                       busy_reg, done_reg;
    logic [alm_pkg::DIV_DW:0]   trial;
    logic                       fits;

    assign trial = {rem_reg, q_reg[alm_pkg::DIV_N-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                q_reg    <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? alm_pkg::DIV_DW'(trial - {1'b0, dvs_reg})
                                : trial[alm_pkg::DIV_DW-1:0];
                q_reg   <= {q_reg[alm_pkg::DIV_N-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == alm_pkg::DIV_CW'(alm_pkg::DIV_N - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

>>> sv/alm_dp.sv
// alm_dp: datapath - energy sum, threshold table build and search, smoother, vad state
// depends on alm_pkg, alm_qmul, alm_div, alm_ram
module alm_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  alm_pkg::cmd_t                  cmd,
    output alm_pkg::st_t                   st,
    input  logic signed [alm_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                           s_frame_last,
    input  logic                           cfg_wr_en,
    input  logic [alm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [alm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic [alm_pkg::LEVEL_W-1:0]    m_level,
    output logic [alm_pkg::LEVEL_W-1:0]    m_amplitude,
    output logic                           m_listening,
    output logic                           m_speech_started,
    output logic                           m_speech_ended,
    output logic [alm_pkg::SEG_W-1:0]      m_segment_samples
);

    logic [alm_pkg::Q_W-1:0] lo_reg, hi_reg, mid_reg, sq_reg, acc_reg, x_reg;
    logic [alm_pkg::Q_W-1:0] mid_calc, mul_a, mul_b, mul_y;
    logic                    mul_done;

    logic [alm_pkg::SUM_W-1:0]   energy_sum_reg, sum_new;
    logic [alm_pkg::FCNT_W-1:0]  frame_count_reg, count_new, close_cnt_reg;
    logic [alm_pkg::LEVEL_W-1:0] smoothed_reg, smoothed_next;
    logic                        active_reg, active_next, started, ended;
    logic [alm_pkg::SIL_W-1:0]   silence_reg, silence_next, sil_sum;
    logic [alm_pkg::LENGTH_BITS-1:0] seglen_reg, seglen_next, seg_base;
    logic [alm_pkg::LENGTH_BITS:0]   seg_sum;
    logic [alm_pkg::THR_W-1:0]   thr_reg;
    logic [alm_pkg::HANG_W-1:0]  hang_reg;

    logic [alm_pkg::TAB_AW-1:0]  k_reg, lvl_reg, probe, ram_addr;
    logic [alm_pkg::BIT_W-1:0]   b_reg;
    logic [alm_pkg::TAB_W-1:0]   ram_q;
    logic [alm_pkg::T_NUM_W-1:0] t_num;
    logic [alm_pkg::T_M_W-1:0]   t_m;
    logic [2*alm_pkg::T_M_W-1:0] t_prod_reg;

    logic                        div_start, div_done;
    logic [alm_pkg::DIV_N-1:0]   div_dividend, div_q;
    logic [alm_pkg::DIV_DW-1:0]  div_divisor;

    logic [alm_pkg::MAG_W:0]     s_ext, s_neg;
    logic [alm_pkg::MAG_W-1:0]   mag;
    logic [2*alm_pkg::MAG_W-1:0] sq;

    logic [alm_pkg::LEVEL_W-1:0] out_level_reg, out_amp_reg;
    logic                        out_listen_reg, out_start_reg, out_end_reg;
    logic [alm_pkg::SEG_W-1:0]   out_seg_reg;

    // bisection and table build
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb begin
        case (cmd.mul_sel)
            alm_pkg::MUL_SQ: begin mul_a = sq_reg;  mul_b = sq_reg; end
            alm_pkg::MUL_AC: begin mul_a = acc_reg; mul_b = sq_reg; end
            default:         begin mul_a = x_reg;   mul_b = lo_reg; end
        endcase
    end

    alm_qmul u_qmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .y       (mul_y)
    );

    always_ff @(posedge aclk) begin
        if (cmd.bis_init) begin
            lo_reg <= alm_pkg::Q_ONE;
            hi_reg <= alm_pkg::Q_TWO;
        end
        if (cmd.bis_load) begin
            mid_reg <= mid_calc;
            sq_reg  <= mid_calc;
            acc_reg <= mid_calc;
        end
        if (cmd.sq_load) begin
            sq_reg <= mul_y;
        end
        if (cmd.ac_load) begin
            acc_reg <= mul_y;
        end
        if (cmd.bis_upd) begin
            if (acc_reg >= alm_pkg::Q_TEN) begin
                hi_reg <= mid_reg;
            end else begin
                lo_reg <= mid_reg;
            end
        end
        if (cmd.tab_init) begin
            x_reg <= alm_pkg::Q_ONE;
            k_reg <= '0;
        end
        if (cmd.x_load) begin
            x_reg <= mul_y;
        end
        if (cmd.tab_div_start) begin
            t_prod_reg <= (2*alm_pkg::T_M_W)'(t_m) * (2*alm_pkg::T_M_W)'(alm_pkg::T_RECIP);
        end
        if (cmd.tab_write) begin
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.srch_init) begin
            lvl_reg <= '0;
            b_reg   <= '1;
        end
        if (cmd.srch_cmp) begin
            if (alm_pkg::DIV_N'(ram_q) <= div_q) begin
                lvl_reg <= probe;
            end
            b_reg <= b_reg - 1'b1;
        end
    end

    assign t_num = alm_pkg::T_NUM_W'(x_reg[alm_pkg::Q_W-1:alm_pkg::T_SHIFT])
                 + alm_pkg::T_NUM_W'(alm_pkg::T_HALF);
    assign t_m      = t_num[alm_pkg::T_NUM_W-1:alm_pkg::T_PRE_SHIFT];
    assign probe    = lvl_reg | (alm_pkg::TAB_AW'(1) << b_reg);
    assign ram_addr = cmd.tab_write ? k_reg : probe - 1'b1;

    alm_ram #(
        .WIDTH (alm_pkg::TAB_W),
        .DEPTH (1 << alm_pkg::TAB_AW)
    ) u_tab (
        .aclk  (aclk),
        .we    (cmd.tab_write),
        .addr  (ram_addr),
        .wdata (t_prod_reg[alm_pkg::T_RECIP_SHIFT +: alm_pkg::TAB_W]),
        .rdata (ram_q)
    );

    // sample accumulation
    assign s_ext   = {s_sample[alm_pkg::SAMPLE_W-1], s_sample};
    assign s_neg   = -s_ext;
    assign mag     = s_sample[alm_pkg::SAMPLE_W-1] ? s_neg[alm_pkg::MAG_W-1:0]
                                                   : s_ext[alm_pkg::MAG_W-1:0];
    assign sq      = mag * mag;
    assign sum_new = energy_sum_reg + alm_pkg::SUM_W'(sq);
    assign count_new = frame_count_reg + 1'b1;

    assign div_start    = cmd.take && st.closing;
    assign div_dividend = sum_new;
    assign div_divisor  = count_new;

    alm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // smoother and speech segment tracking
    always_comb begin
        smoothed_next = smoothed_reg;
        if (smoothed_reg < lvl_reg) begin
            smoothed_next = smoothed_reg + ((lvl_reg - smoothed_reg) >> 1) + 1'b1;
        end else if (smoothed_reg > lvl_reg) begin
            smoothed_next = smoothed_reg - ((smoothed_reg - lvl_reg) >> 2) - 1'b1;
        end

        active_next  = active_reg;
        silence_next = silence_reg;
        started      = 1'b0;
        ended        = 1'b0;
        sil_sum      = silence_reg + alm_pkg::SIL_W'(close_cnt_reg);
        if (lvl_reg > thr_reg) begin
            if (!active_reg) begin
                active_next = 1'b1;
                started     = 1'b1;
            end
            silence_next = '0;
        end else if (active_reg) begin
            silence_next = sil_sum;
            if (sil_sum >= alm_pkg::SIL_W'(hang_reg)) begin
                active_next = 1'b0;
                ended       = 1'b1;
            end
        end

        seg_base    = started ? '0 : seglen_reg;
        seg_sum     = {1'b0, seg_base} + (alm_pkg::LENGTH_BITS + 1)'(close_cnt_reg);
        seglen_next = seglen_reg;
        if (active_next) begin
            seglen_next = seg_sum[alm_pkg::LENGTH_BITS] ? '1
                                                        : seg_sum[alm_pkg::LENGTH_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            energy_sum_reg  <= '0;
            frame_count_reg <= '0;
            smoothed_reg    <= '0;
            active_reg      <= 1'b0;
            silence_reg     <= '0;
            seglen_reg      <= '0;
            thr_reg         <= alm_pkg::THR_RESET;
            hang_reg        <= alm_pkg::HANG_RESET;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    alm_pkg::CFG_SPEECH_THRESHOLD: thr_reg  <= cfg_wdata[alm_pkg::THR_W-1:0];
                    alm_pkg::CFG_HANGOVER_SAMPLES: hang_reg <= cfg_wdata[alm_pkg::HANG_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.take) begin
                if (st.closing) begin
                    energy_sum_reg  <= '0;
                    frame_count_reg <= '0;
                end else begin
                    energy_sum_reg  <= sum_new;
                    frame_count_reg <= count_new;
                end
            end
            if (cmd.out_load) begin
                smoothed_reg <= smoothed_next;
                active_reg   <= active_next;
                silence_reg  <= silence_next;
                seglen_reg   <= seglen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take && st.closing) begin
            close_cnt_reg <= count_new;
        end
        if (cmd.out_load) begin
            out_level_reg  <= lvl_reg;
            out_amp_reg    <= smoothed_next;
            out_listen_reg <= active_next;
            out_start_reg  <= started;
            out_end_reg    <= ended;
            out_seg_reg    <= alm_pkg::SEG_W'(seglen_next);
        end
    end

    assign st.bis_done = (hi_reg - lo_reg) == alm_pkg::Q_W'(1);
    assign st.mul_done = mul_done;
    assign st.div_done = div_done;
    assign st.tab_last = k_reg == alm_pkg::TAB_AW'(alm_pkg::TAB_DEPTH - 1);
    assign st.closing  = s_frame_last
                       || (frame_count_reg == alm_pkg::FCNT_W'(alm_pkg::MAX_FRAME - 1));
    assign st.bit_zero = b_reg == '0;

    assign m_level           = out_level_reg;
    assign m_amplitude       = out_amp_reg;
    assign m_listening       = out_listen_reg;
    assign m_speech_started  = out_start_reg;
    assign m_speech_ended    = out_end_reg;
    assign m_segment_samples = out_seg_reg;

endmodule

>>> sv/alm_ctrl.sv
// alm_ctrl: controller state machine - table build after reset, frame close sequencing
// depends on alm_pkg
module alm_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  alm_pkg::st_t  st,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output alm_pkg::cmd_t cmd
);

    alm_pkg::state_t            state_reg, state_next;
    logic [alm_pkg::PCNT_W-1:0] pcnt_reg, pcnt_next;
    logic                       m_valid_reg, m_valid_next;
    logic                       out_free, take, pow_last;

    assign out_free = !m_valid_reg || m_ready;
    assign take     = (state_reg == alm_pkg::ST_IDLE) && s_valid;
    assign pow_last = pcnt_reg == alm_pkg::PCNT_W'(alm_pkg::POW_STEPS - 1);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            alm_pkg::ST_BIS_INIT:  state_next = alm_pkg::ST_BIS_CHECK;
            alm_pkg::ST_BIS_CHECK: state_next = st.bis_done ? alm_pkg::ST_TAB_INIT
                                                            : alm_pkg::ST_SQ_START;
            alm_pkg::ST_SQ_START:  state_next = alm_pkg::ST_SQ_WAIT;
            alm_pkg::ST_SQ_WAIT: begin
                if (st.mul_done) state_next = alm_pkg::ST_AC_START;
            end
            alm_pkg::ST_AC_START:  state_next = alm_pkg::ST_AC_WAIT;
            alm_pkg::ST_AC_WAIT: begin
                if (st.mul_done) begin
                    state_next = pow_last ? alm_pkg::ST_BIS_UPD : alm_pkg::ST_SQ_START;
                end
            end
            alm_pkg::ST_BIS_UPD:   state_next = alm_pkg::ST_BIS_CHECK;
            alm_pkg::ST_TAB_INIT:  state_next = alm_pkg::ST_TX_START;
            alm_pkg::ST_TX_START:  state_next = alm_pkg::ST_TX_WAIT;
            alm_pkg::ST_TX_WAIT: begin
                if (st.mul_done) state_next = alm_pkg::ST_TD_START;
            end
            alm_pkg::ST_TD_START:  state_next = alm_pkg::ST_TD_WAIT;
            alm_pkg::ST_TD_WAIT: begin
                state_next = st.tab_last ? alm_pkg::ST_IDLE : alm_pkg::ST_TX_START;
            end
            alm_pkg::ST_IDLE: begin
                if (take && st.closing) state_next = alm_pkg::ST_MEAN_WAIT;
            end
            alm_pkg::ST_MEAN_WAIT: begin
                if (st.div_done) state_next = alm_pkg::ST_SR_ADDR;
            end
            alm_pkg::ST_SR_ADDR:   state_next = alm_pkg::ST_SR_CMP;
            alm_pkg::ST_SR_CMP:    state_next = st.bit_zero ? alm_pkg::ST_UPDATE
                                                            : alm_pkg::ST_SR_ADDR;
            alm_pkg::ST_UPDATE: begin
                if (out_free) state_next = alm_pkg::ST_IDLE;
            end
            default:               state_next = alm_pkg::ST_BIS_INIT;
        endcase
    end

    always_comb begin
        cmd           = '0;
        cmd.mul_sel   = alm_pkg::MUL_TX;
        pcnt_next     = pcnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        case (state_reg)
            alm_pkg::ST_BIS_INIT:  cmd.bis_init = 1'b1;
            alm_pkg::ST_BIS_CHECK: begin
                cmd.bis_load = !st.bis_done;
                pcnt_next    = '0;
            end
            alm_pkg::ST_SQ_START: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = alm_pkg::MUL_SQ;
            end
            alm_pkg::ST_SQ_WAIT:   cmd.sq_load = st.mul_done;
            alm_pkg::ST_AC_START: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = alm_pkg::MUL_AC;
            end
            alm_pkg::ST_AC_WAIT: begin
                cmd.ac_load = st.mul_done;
                if (st.mul_done) pcnt_next = pcnt_reg + 1'b1;
            end
            alm_pkg::ST_BIS_UPD:   cmd.bis_upd = 1'b1;
            alm_pkg::ST_TAB_INIT:  cmd.tab_init = 1'b1;
            alm_pkg::ST_TX_START:  cmd.mul_start = 1'b1;
            alm_pkg::ST_TX_WAIT:   cmd.x_load = st.mul_done;
            alm_pkg::ST_TD_START:  cmd.tab_div_start = 1'b1;
            alm_pkg::ST_TD_WAIT:   cmd.tab_write = 1'b1;
            alm_pkg::ST_IDLE:      cmd.take = take;
            alm_pkg::ST_MEAN_WAIT: cmd.srch_init = st.div_done;
            alm_pkg::ST_SR_CMP:    cmd.srch_cmp = 1'b1;
            alm_pkg::ST_UPDATE: begin
                cmd.out_load = out_free;
                if (out_free) m_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= alm_pkg::ST_BIS_INIT;
            pcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pcnt_reg    <= pcnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = state_reg == alm_pkg::ST_IDLE;
    assign m_valid = m_valid_reg;

endmodule

>>> sv/audio_level_meter_vad_core.sv
// audio_level_meter_vad_core: top level of the frame energy level meter and speech detector
// depends on alm_pkg, alm_ctrl, alm_dp (and through it alm_qmul, alm_div, alm_ram)
//
//   channel | ports                                    | transfer
//   s_      | s_sample, s_frame_last                   | one sample request
//   m_      | m_level .. m_segment_samples             | one result per closed frame
//   cfg_    | cfg_wr_en, cfg_addr, cfg_wdata           | register write, no wait
//
// after reset the threshold table is built, s_ready low meanwhile
// a sample that does not close its frame leaves s_ready high, so intake goes on
// a closing sample runs the mean divider, then the table search, then the update
// a pending result does not block sample requests until the next frame closes
module audio_level_meter_vad_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [alm_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                s_frame_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [alm_pkg::LEVEL_W-1:0]         m_level,
    output logic [alm_pkg::LEVEL_W-1:0]         m_amplitude,
    output logic                                m_listening,
    output logic                                m_speech_started,
    output logic                                m_speech_ended,
    output logic [alm_pkg::SEG_W-1:0]           m_segment_samples,
    input  logic                                cfg_wr_en,
    input  logic [alm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [alm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    alm_pkg::cmd_t cmd;
    alm_pkg::st_t  st;

    alm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .st      (st),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    alm_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .st                (st),
        .s_sample          (s_sample),
        .s_frame_last      (s_frame_last),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .m_level           (m_level),
        .m_amplitude       (m_amplitude),
        .m_listening       (m_listening),
        .m_speech_started  (m_speech_started),
        .m_speech_ended    (m_speech_ended),
        .m_segment_samples (m_segment_samples)
    );

    a_close_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && st.closing |=> !s_ready)
        else $error("closing sample did not stop intake");

    a_start_listens: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_speech_started |-> m_listening && !m_speech_ended)
        else $error("segment start without listening");

    a_end_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_speech_ended |-> !m_listening)
        else $error("segment end while listening");

endmodule
